[design/bivariate_gaussian_eval_top_macros.svh]
// Assertion macros for the bivariate Gaussian evaluator.
// Expects clk and arst_n in the scope of each use.
`ifndef BIVARIATE_GAUSSIAN_EVAL_TOP_MACROS_SVH
`define BIVARIATE_GAUSSIAN_EVAL_TOP_MACROS_SVH

// Same-cycle implication.
`define BGE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BGE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bge_pkg.sv]
// Shared types, constants and table builder for the bivariate Gaussian evaluator.
// No dependencies.
package bge_pkg;

	localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;
	localparam int unsigned CFG_ADDR_W = 5;
	// quadratic form, Q.30, never above 2^46
	localparam int unsigned Q_W = 47;

	localparam logic signed [15:0] MEAN_RST = 16'sd0;
	localparam logic [15:0] INV_WIDTH_RST = 16'd4096;
	localparam logic signed [14:0] CORR_RST = 15'sd0;
	localparam logic [15:0] GAIN_RST = 16'd2048;

	typedef enum logic [2:0] {
		REG_MEAN_A = 3'd0,
		REG_MEAN_B = 3'd1,
		REG_INV_WIDTH_A = 3'd2,
		REG_INV_WIDTH_B = 3'd3,
		REG_CORR = 3'd4,
		REG_GAIN = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] mean_a;
		logic signed [15:0] mean_b;
		logic [15:0] inv_width_a;
		logic [15:0] inv_width_b;
		logic signed [14:0] corr;
	} geom_cfg_t;

	// 65536*exp(-32*targ/2^31): exp(-targ/2^31) in Q31 by Taylor series,
	// squared five times, then scaled to Q16 and capped.
	function automatic logic [15:0] exp_entry(input longint unsigned targ);
		longint unsigned term;
		longint sum;
		longint unsigned e;
		longint unsigned r;
		term = 64'd1 << 31;
		sum = longint'(term);
		term = (term * targ) >> 31;         sum = sum - longint'(term);
		term = ((term * targ) >> 31) / 2;   sum = sum + longint'(term);
		term = ((term * targ) >> 31) / 3;   sum = sum - longint'(term);
		term = ((term * targ) >> 31) / 4;   sum = sum + longint'(term);
		term = ((term * targ) >> 31) / 5;   sum = sum - longint'(term);
		term = ((term * targ) >> 31) / 6;   sum = sum + longint'(term);
		term = ((term * targ) >> 31) / 7;   sum = sum - longint'(term);
		term = ((term * targ) >> 31) / 8;   sum = sum + longint'(term);
		term = ((term * targ) >> 31) / 9;   sum = sum - longint'(term);
		term = ((term * targ) >> 31) / 10;  sum = sum + longint'(term);
		term = ((term * targ) >> 31) / 11;  sum = sum - longint'(term);
		term = ((term * targ) >> 31) / 12;  sum = sum + longint'(term);
		e = (sum < 0) ? 64'd0 : 64'(sum);
		for (int k = 0; k < 5; k++) begin
			e = (e * e + (64'd1 << 30)) >> 31;
		end
		r = (e + (64'd1 << 14)) >> 15;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

endpackage

[design/bivariate_gaussian_eval_top.sv]
// Bivariate Gaussian evaluator, fully pipelined: one point per clock while
// s_tready is high. A point accepted on s_tdata passes through eleven register
// stages (distance multiply, round and saturate, square and cross products,
// correlation multiply, quadratic form, two-part gain multiply, position add,
// index split, table read, interpolation multiply, clamp) plus the output
// register before it appears on m_tdata. A second output slot absorbs one
// transaction when m_tready drops, and s_tready falls only while that slot is
// occupied. Configuration registers are to be written over APB by the user only
// while no transaction is in flight; the block does not enforce this. Depends
// on bge_pkg, bge_quad, bge_expo, bge_interp and the assertion macro header.
`include "bivariate_gaussian_eval_top_macros.svh"

module bivariate_gaussian_eval_top #(
	parameter int unsigned EXP_TABLE_DEPTH = bge_pkg::EXP_TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	// APB configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [bge_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// input points
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // [15:0] coord_a, [31:16] coord_b
	// results
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata // [15:0] density
);
	import bge_pkg::*;

	localparam int unsigned GD_W = 16 + $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);

	logic signed [15:0] mean_a_q, mean_b_q;
	logic [15:0] inv_width_a_q, inv_width_b_q, gain_q;
	logic signed [14:0] corr_q;
	logic [GD_W-1:0] gd_q;

	logic cfg_wr;
	logic [2:0] cfg_idx;
	geom_cfg_t geom;

	logic en;
	logic quad_valid, expo_valid, lut_valid;
	logic [Q_W-1:0] quad;
	logic [IDX_W-1:0] idx;
	logic [15:0] frac;
	logic under;
	logic [15:0] density;
	logic push;

	logic out_v_q, skid_v_q;
	logic [15:0] out_d_q, skid_d_q;

	// ---- configuration ----
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_a_q <= MEAN_RST;
			mean_b_q <= MEAN_RST;
			inv_width_a_q <= INV_WIDTH_RST;
			inv_width_b_q <= INV_WIDTH_RST;
			corr_q <= CORR_RST;
			gain_q <= GAIN_RST;
			gd_q <= GD_W'(GAIN_RST * EXP_TABLE_DEPTH);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MEAN_A: mean_a_q <= pwdata[15:0];
				REG_MEAN_B: mean_b_q <= pwdata[15:0];
				REG_INV_WIDTH_A: inv_width_a_q <= pwdata[15:0];
				REG_INV_WIDTH_B: inv_width_b_q <= pwdata[15:0];
				REG_CORR: corr_q <= pwdata[14:0];
				REG_GAIN: begin
					gain_q <= pwdata[15:0];
					// gain pre-scaled by table depth
					gd_q <= GD_W'(pwdata[15:0] * EXP_TABLE_DEPTH);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MEAN_A: prdata = 32'(mean_a_q);
			REG_MEAN_B: prdata = 32'(mean_b_q);
			REG_INV_WIDTH_A: prdata = {16'd0, inv_width_a_q};
			REG_INV_WIDTH_B: prdata = {16'd0, inv_width_b_q};
			REG_CORR: prdata = 32'(corr_q);
			REG_GAIN: prdata = {16'd0, gain_q};
			default: prdata = '0;
		endcase
	end

	assign geom = '{
		mean_a: mean_a_q,
		mean_b: mean_b_q,
		inv_width_a: inv_width_a_q,
		inv_width_b: inv_width_b_q,
		corr: corr_q
	};

	// ---- datapath ----
	// whole pipeline advances unless the spare output slot is taken
	assign en = !skid_v_q;
	assign s_tready = en;

	bge_quad u_quad (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_tvalid),
		.coord_a(s_tdata[15:0]),
		.coord_b(s_tdata[31:16]),
		.geom(geom),
		.out_valid(quad_valid),
		.quad(quad)
	);

	bge_expo #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_expo (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(quad_valid),
		.quad(quad),
		.gd(gd_q),
		.out_valid(expo_valid),
		.idx(idx),
		.frac(frac),
		.under(under)
	);

	bge_interp #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(expo_valid),
		.idx(idx),
		.frac(frac),
		.under(under),
		.out_valid(lut_valid),
		.density(density)
	);

	// ---- output register with skid slot ----
	assign push = en & lut_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_d_q <= skid_d_q;
			end else if (push) begin
				out_d_q <= density;
			end
		end else if (push) begin
			skid_d_q <= density;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_d_q;

	// ---- checks ----
	`BGE_ASSERT_IMP(a_skid_behind_out, skid_v_q, m_tvalid, "skid slot full with output empty")
	`BGE_ASSERT_NXT(a_no_drop, m_tvalid && !m_tready && push, skid_v_q, "result dropped on stall")
	`BGE_ASSERT_NXT(a_stall_holds, !en, lut_valid == $past(lut_valid), "pipeline moved during stall")
	`BGE_ASSERT_IMP(a_gd_matches, 1'b1, gd_q == GD_W'(gain_q * EXP_TABLE_DEPTH), "scaled gain stale")

endmodule

[design/bge_quad.sv]
// Front pipeline: scaled distances and the correlated quadratic form (stages 1-5).
// Depends on bge_pkg.
module bge_quad (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [15:0] coord_a,
	input logic signed [15:0] coord_b,
	input bge_pkg::geom_cfg_t geom,
	output logic out_valid,
	output logic [bge_pkg::Q_W-1:0] quad
);
	import bge_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [32:0] pa_s1, pb_s1;
	logic signed [15:0] ua_s2, ub_s2;
	logic [30:0] uu_s3, ww_s3;
	logic signed [31:0] uw_s3;
	logic [31:0] sq_s4;
	logic signed [45:0] cuw_s4;
	logic [Q_W-1:0] q_s5;

	logic signed [16:0] da, db;
	logic signed [33:0] pa_full, pb_full;
	logic signed [33:0] ra, rb;
	logic signed [31:0] uu_full, ww_full, uw_full;
	logic [31:0] sq;
	logic signed [46:0] cuw_full;
	logic signed [47:0] qv;

	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		if (v > 22'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -22'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	assign da = $signed({coord_a[15], coord_a}) - $signed({geom.mean_a[15], geom.mean_a});
	assign db = $signed({coord_b[15], coord_b}) - $signed({geom.mean_b[15], geom.mean_b});
	assign pa_full = da * $signed({1'b0, geom.inv_width_a});
	assign pb_full = db * $signed({1'b0, geom.inv_width_b});

	// round half up at 2^-12, then saturate to Q8.8
	assign ra = $signed({pa_s1[32], pa_s1}) + 34'sd2048;
	assign rb = $signed({pb_s1[32], pb_s1}) + 34'sd2048;

	assign uu_full = ua_s2 * ua_s2;
	assign ww_full = ub_s2 * ub_s2;
	assign uw_full = ua_s2 * ub_s2;

	assign sq = {1'b0, uu_s3} + {1'b0, ww_s3};
	assign cuw_full = $signed(geom.corr) * uw_s3;

	assign qv = $signed({2'b00, sq_s4, 14'd0}) - $signed({cuw_s4[45], cuw_s4, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= pa_full[32:0];
			pb_s1 <= pb_full[32:0];
			ua_s2 <= sat16(ra[33:12]);
			ub_s2 <= sat16(rb[33:12]);
			uu_s3 <= uu_full[30:0];
			ww_s3 <= ww_full[30:0];
			uw_s3 <= uw_full;
			sq_s4 <= sq;
			cuw_s4 <= cuw_full[45:0];
			q_s5 <= qv[47] ? '0 : qv[Q_W-1:0];
		end
	end

	assign out_valid = v_s5;
	assign quad = q_s5;

endmodule

[design/bge_expo.sv]
// Middle pipeline: exponent times gain and table depth, split into
// table index and fraction, with underflow detect (stages 6-8). Depends on bge_pkg.
module bge_expo #(
	parameter int unsigned EXP_TABLE_DEPTH = bge_pkg::EXP_TABLE_DEPTH_DEF,
	localparam int unsigned GD_W = 16 + $clog2(EXP_TABLE_DEPTH),
	localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [bge_pkg::Q_W-1:0] quad,
	input logic [GD_W-1:0] gd,
	output logic out_valid,
	output logic [IDX_W-1:0] idx,
	output logic [15:0] frac,
	output logic under
);
	import bge_pkg::*;

	localparam int unsigned LO_W = 24;
	localparam int unsigned HI_W = Q_W - LO_W;
	localparam int unsigned PL_W = LO_W + GD_W;
	localparam int unsigned PH_W = HI_W + GD_W;
	localparam int unsigned POS_W = Q_W + GD_W;
	localparam int unsigned TOP_W = POS_W - 46;

	logic v_s6, v_s7, v_s8;
	logic [PL_W-1:0] pl_s6;
	logic [PH_W-1:0] ph_s6;
	logic [POS_W-1:0] pos_s7;
	logic [IDX_W-1:0] idx_s8;
	logic [15:0] frac_s8;
	logic under_s8;

	logic [PL_W-1:0] pl;
	logic [PH_W-1:0] ph;
	logic [POS_W-1:0] pos;
	logic [TOP_W-1:0] top;

	assign pl = quad[LO_W-1:0] * gd;
	assign ph = quad[Q_W-1:LO_W] * gd;
	assign pos = (POS_W'(ph_s6) << LO_W) + POS_W'(pl_s6);
	// integer part of the exponent times depth/16; at or above depth means exponent >= 16
	assign top = pos_s7[POS_W-1:46];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= in_valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s6 <= pl;
			ph_s6 <= ph;
			pos_s7 <= pos;
			idx_s8 <= top[IDX_W-1:0];
			frac_s8 <= pos_s7[45:30];
			under_s8 <= (top >= TOP_W'(EXP_TABLE_DEPTH));
		end
	end

	assign out_valid = v_s8;
	assign idx = idx_s8;
	assign frac = frac_s8;
	assign under = under_s8;

endmodule

[design/bge_interp.sv]
// Back pipeline: exponential table in even/odd banks, linear interpolation
// and output clamp (stages 9-11). Depends on bge_pkg.
module bge_interp #(
	parameter int unsigned EXP_TABLE_DEPTH = bge_pkg::EXP_TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [IDX_W-1:0] idx,
	input logic [15:0] frac,
	input logic under,
	output logic out_valid,
	output logic [15:0] density
);
	import bge_pkg::*;

	// entries 0..depth split so that idx and idx+1 always hit different banks
	localparam int unsigned NE = EXP_TABLE_DEPTH / 2 + 1;
	localparam int unsigned NO = (EXP_TABLE_DEPTH + 1) / 2;
	localparam int unsigned EW = $clog2(NE);
	localparam int unsigned OW = $clog2(NO);

	logic [15:0] even_rom [NE];
	logic [15:0] odd_rom [NO];

	for (genvar g = 0; g < NE; g++) begin : g_even
		localparam longint unsigned TA = (64'(2 * g) << 30) / EXP_TABLE_DEPTH;
		localparam logic [15:0] VAL = exp_entry(TA);
		assign even_rom[g] = VAL;
	end

	for (genvar g = 0; g < NO; g++) begin : g_odd
		localparam longint unsigned TA = (64'(2 * g + 1) << 30) / EXP_TABLE_DEPTH;
		localparam logic [15:0] VAL = exp_entry(TA);
		assign odd_rom[g] = VAL;
	end

	logic v_s9, v_s10, v_s11;
	logic [15:0] e_rd_s9, o_rd_s9, frac_s9;
	logic odd_s9, under_s9;
	logic [15:0] t0_s10;
	logic signed [32:0] prod_s10;
	logic under_s10;
	logic [15:0] dens_s11;

	logic [EW-1:0] ea;
	logic [OW-1:0] oa;
	logic [15:0] t0, t1;
	logic signed [16:0] dt;
	logic signed [33:0] prod_full;
	logic signed [34:0] r;
	logic [15:0] dens;

	assign ea = EW'(idx >> 1) + EW'(idx[0]);
	assign oa = OW'(idx >> 1);

	assign t0 = odd_s9 ? o_rd_s9 : e_rd_s9;
	assign t1 = odd_s9 ? e_rd_s9 : o_rd_s9;
	assign dt = $signed({1'b0, t0}) - $signed({1'b0, t1});
	assign prod_full = dt * $signed({1'b0, frac_s9});

	assign r = $signed({3'b000, t0_s10, 16'd0}) - $signed({{2{prod_s10[32]}}, prod_s10})
		+ 35'sd32768;

	always_comb begin
		priority if (under_s10 || r[34]) begin
			dens = '0;
		end else if (r[33:32] != 2'b00) begin
			dens = 16'hFFFF;
		end else begin
			dens = r[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s9 <= in_valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_rd_s9 <= even_rom[ea];
			o_rd_s9 <= odd_rom[oa];
			odd_s9 <= idx[0];
			frac_s9 <= frac;
			under_s9 <= under;
			t0_s10 <= t0;
			prod_s10 <= prod_full[32:0];
			under_s10 <= under_s9;
			dens_s11 <= dens;
		end
	end

	assign out_valid = v_s11;
	assign density = dens_s11;

endmodule
